>>> design/chlcd_pkg.sv
// Package for the character display 4-bit sequencer.
// Request/phase payload types, mode and register codes, init tables.
// No dependencies.
package chlcd_pkg;

  localparam int ROW_COUNT   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int INIT_NIBS   = 12;
  localparam int NIB_IDX_W   = $clog2(INIT_NIBS);

  localparam logic [12:0] HOLD_SHORT   = 13'd1;
  localparam logic [12:0] HOLD_NIBBLE  = 13'd100;
  localparam logic [12:0] WAIT_POWERUP = 13'd4500;
  localparam logic [12:0] WAIT_SHORT   = 13'd150;
  localparam logic [12:0] WAIT_CLEAR   = 13'd2000;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_DISP_CTL = 8'h08;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;
  localparam logic [7:0] ROW_ODD_OFS  = 8'h40;
  localparam logic [2:0] DISP_ON_BIT  = 3'b100;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_CMD     = 3'd1,
    MODE_DATA    = 3'd2,
    MODE_CURSOR  = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_HOME    = 3'd5,
    MODE_DISP_ON = 3'd6
  } mode_e;

  // spare mode code: taken and dropped
  localparam logic [2:0] MODE_IGNORED = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS    = 2'd0,
    CFG_LINE_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_STROBE = 2'd1,
    PH_HOLD   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] byte_value;
    logic [6:0] column;
    logic [2:0] row;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_pin;
    logic [3:0]  data_nibble;
    logic [12:0] hold_us;
    logic        last;
  } rsp_t;

  // decoded request handed from the input stage to the phase emitter
  typedef struct packed {
    logic       init;
    logic       reg_select;
    logic [7:0] byte_value;
    logic       long_wait;
  } plan_t;

  // init nibble stream: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
  function automatic logic [3:0] init_nibble(input logic [NIB_IDX_W-1:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'hC;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h1;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [12:0] init_extra(input logic [NIB_IDX_W-1:0] idx);
    logic [12:0] w;
    unique case (idx)
      4'd0, 4'd1: w = WAIT_POWERUP;
      4'd2:       w = WAIT_SHORT;
      4'd9:       w = WAIT_CLEAR;
      default:    w = 13'd0;
    endcase
    return w;
  endfunction

endpackage

>>> design/chlcd_req.sv
// Input stage: config registers, display control state, request decode and
// the request register. Depends on chlcd_pkg.
module chlcd_req #(
  parameter int ROW_COUNT = chlcd_pkg::ROW_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  chlcd_pkg::req_t                   in_data,
  input  logic                              cfg_valid,
  input  logic [chlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chlcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              plan_done,
  output logic                              plan_valid,
  output chlcd_pkg::plan_t                  plan
);
  import chlcd_pkg::*;

  logic [5:0] columns_r, columns_nxt;
  logic [2:0] lines_r, lines_nxt;
  logic [2:0] dcb_r, dcb_nxt;
  logic       req_valid_r, req_valid_nxt;
  plan_t      plan_r, plan_nxt;

  logic       accept;
  logic       legal;
  logic [2:0] row_c;
  logic [2:0] row_max;
  logic [2:0] lines_eff;
  logic [7:0] offset;
  logic [7:0] cursor_cmd;

  assign in_stall = req_valid_r && !plan_done;
  assign accept   = in_valid && !in_stall;
  assign legal    = (in_data.mode != MODE_IGNORED);

  // cursor address: clamp row, then add row offset to column
  always_comb begin
    row_max   = 3'(ROW_COUNT - 1);
    lines_eff = (lines_r == 3'd0) ? 3'd1 : lines_r;
    row_c     = (in_data.row > row_max) ? row_max : in_data.row;
    if (row_c >= lines_eff) begin
      row_c = lines_eff - 3'd1;
    end
    offset     = (row_c[0] ? ROW_ODD_OFS : 8'd0) +
                 ((row_c >= 3'd2) ? {2'b00, columns_r} : 8'd0);
    cursor_cmd = CMD_DDRAM | ({1'b0, in_data.column} + offset);
  end

  always_comb begin
    columns_nxt = columns_r;
    lines_nxt   = lines_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMNS:    columns_nxt = cfg_data;
        CFG_LINE_COUNT: lines_nxt   = cfg_data[2:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    dcb_nxt             = dcb_r;
    plan_nxt            = plan_r;
    req_valid_nxt       = plan_done ? 1'b0 : req_valid_r;
    plan_nxt.init       = 1'b0;
    plan_nxt.reg_select = 1'b0;
    plan_nxt.byte_value = in_data.byte_value;
    plan_nxt.long_wait  = 1'b0;
    unique case (mode_e'(in_data.mode))
      MODE_INIT:    plan_nxt.init = 1'b1;
      MODE_CMD:     ;
      MODE_DATA:    plan_nxt.reg_select = 1'b1;
      MODE_CURSOR:  plan_nxt.byte_value = cursor_cmd;
      MODE_CLEAR: begin
        plan_nxt.byte_value = CMD_CLEAR;
        plan_nxt.long_wait  = 1'b1;
      end
      MODE_HOME: begin
        plan_nxt.byte_value = CMD_HOME;
        plan_nxt.long_wait  = 1'b1;
      end
      MODE_DISP_ON: plan_nxt.byte_value = CMD_DISP_CTL | {5'd0, dcb_r | DISP_ON_BIT};
      default:      ;
    endcase
    if (!(accept && legal)) begin
      plan_nxt = plan_r;
    end else begin
      req_valid_nxt = 1'b1;
      if (mode_e'(in_data.mode) == MODE_INIT) begin
        dcb_nxt = DISP_ON_BIT;
      end else if (mode_e'(in_data.mode) == MODE_DISP_ON) begin
        dcb_nxt = dcb_r | DISP_ON_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r   <= 6'd16;
      lines_r     <= 3'd2;
      dcb_r       <= 3'd0;
      req_valid_r <= 1'b0;
    end else begin
      columns_r   <= columns_nxt;
      lines_r     <= lines_nxt;
      dcb_r       <= dcb_nxt;
      req_valid_r <= req_valid_nxt;
    end
    plan_r <= plan_nxt;
  end

  assign plan_valid = req_valid_r;
  assign plan       = plan_r;

endmodule

>>> design/chlcd_phase.sv
// Phase emitter: walks nibbles and enable phases of the held request and loads one
// pin phase per cycle into the output register while out_stall is low. Depends on chlcd_pkg.
module chlcd_phase (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             plan_valid,
  input  chlcd_pkg::plan_t plan,
  output logic             plan_done,
  output logic             out_valid,
  input  logic             out_stall,
  output chlcd_pkg::rsp_t  out_data
);
  import chlcd_pkg::*;

  phase_e                ph_r, ph_nxt;
  logic [NIB_IDX_W-1:0]  nib_r, nib_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  out_data_r;
  rsp_t                  cur;
  logic                  load;
  logic                  last_nib;
  logic [12:0]           extra;

  assign load      = plan_valid && (!out_valid_r || !out_stall);
  assign last_nib  = plan.init ? (nib_r == NIB_IDX_W'(INIT_NIBS - 1))
                               : (nib_r == NIB_IDX_W'(1));
  assign plan_done = load && cur.last;

  // next state
  always_comb begin
    ph_nxt  = ph_r;
    nib_nxt = nib_r;
    if (load) begin
      unique case (ph_r)
        PH_SETUP:  ph_nxt = PH_STROBE;
        PH_STROBE: ph_nxt = PH_HOLD;
        PH_HOLD: begin
          ph_nxt  = PH_SETUP;
          nib_nxt = last_nib ? '0 : nib_r + NIB_IDX_W'(1);
        end
        default:   ph_nxt = PH_SETUP;
      endcase
    end
  end

  // phase outputs
  always_comb begin
    if (plan.init) begin
      extra           = init_extra(nib_r);
      cur.data_nibble = init_nibble(nib_r);
    end else begin
      extra           = (nib_r[0] && plan.long_wait) ? WAIT_CLEAR : 13'd0;
      cur.data_nibble = nib_r[0] ? plan.byte_value[3:0] : plan.byte_value[7:4];
    end
    cur.reg_select = plan.reg_select;
    cur.enable_pin = (ph_r == PH_STROBE);
    cur.hold_us    = (ph_r == PH_HOLD) ? HOLD_NIBBLE + extra : HOLD_SHORT;
    cur.last       = last_nib && (ph_r == PH_HOLD);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = plan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_SETUP;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_data_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/char_lcd_4bit_sequencer.sv
// Top level of the 4-bit character display sequencer.
// Instantiates chlcd_req and chlcd_phase; depends on chlcd_pkg.
//
// Turns display requests into a stream of pin phases (register select,
// enable level, d4..d7 nibble, hold time in us, last flag), one phase per
// clock while out_stall is low. Command, data, cursor, clear, home and
// display-on requests give 6 phases (two nibbles of three phases each);
// init gives 36. The next request is taken in the same cycle the last
// phase of the current one is loaded into the output register, so
// phases of consecutive requests follow with no gap. Mode 7 is accepted
// and dropped. ROW_COUNT is the number of physical rows the cursor row is
// clamped to. cfg_ready is always high; registers should be written only
// while no request is in flight.
module char_lcd_4bit_sequencer #(
  parameter int ROW_COUNT = chlcd_pkg::ROW_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  chlcd_pkg::req_t                   in_data,
  // phase channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output chlcd_pkg::rsp_t                   out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chlcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import chlcd_pkg::*;

  plan_t plan;
  logic  plan_valid;
  logic  plan_done;

  assign cfg_ready = 1'b1;

  // request register: decode, cursor math, config and control state
  chlcd_req #(
    .ROW_COUNT (ROW_COUNT)
  ) u_req (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .plan_done  (plan_done),
    .plan_valid (plan_valid),
    .plan       (plan)
  );

  // phase walker and output register
  chlcd_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_done  (plan_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> design/chlcd_checker.sv
// Port-level checks for the character display sequencer, bound to the top.
// Depends on chlcd_pkg.
module chlcd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input chlcd_pkg::req_t                   in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input chlcd_pkg::rsp_t                   out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [chlcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [chlcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import chlcd_pkg::*;

  // a stalled phase holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("phase changed under stall");

  // strobe phases are short and never end a request
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.enable_pin |-> out_data.hold_us == HOLD_SHORT && !out_data.last)
    else $error("bad strobe phase");

  // a request ends on enable low with at least the nibble hold
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !out_data.enable_pin && out_data.hold_us >= HOLD_NIBBLE)
    else $error("bad final phase");

  // output empty after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind char_lcd_4bit_sequencer chlcd_checker u_chlcd_checker (.*);
